/* sv/modular_arithmetic_unit_defines.svh */
// Assertion macros shared by the checker of the modular arithmetic unit.
// No dependencies.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define MAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("mau assertion failed");

// next-cycle implication
`define MAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("mau assertion failed");

`endif

/* sv/mau_pkg.sv */
// Package for the modular arithmetic unit: widths, opcodes, beat structs,
// controller commands and status. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;
	localparam int MW       = 31;
	localparam int OPW      = 64;
	localparam int EXP_BITS = 64;
	localparam int ECNT_W   = $clog2(EXP_BITS + 1);
	localparam int SW       = MW + 3;
	localparam int CNT_W    = 6;
	localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(OPW - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MW - 1);
	localparam logic [MW-1:0] MOD_RESET = MW'(1000000007);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	typedef struct packed {
		logic [2:0]            opcode;
		logic signed [OPW-1:0] operand_a;
		logic signed [OPW-1:0] operand_b;
		logic [OPW-1:0]        exponent;
	} req_t;

	typedef struct packed {
		logic [MW-1:0] result;
		logic          no_inverse;
	} rsp_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_RED, CMD_FIX, CMD_ADDSUB, CMD_ZERO, CMD_FLAG,
		CMD_MSET_AB, CMD_MSET_AI, CMD_MSET_PA, CMD_MSET_PS, CMD_MSTEP,
		CMD_MWB_RES, CMD_MWB_ACC, CMD_MWB_SQ, CMD_POW_INIT, CMD_POW_RES,
		CMD_EU_INIT, CMD_EU_DSET, CMD_EU_DSTEP, CMD_EU_UPD, CMD_EU_FIN
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       mod_small;
		logic       red_last;
		logic       mul_last;
		logic       r_zero;
		logic       inv_ok;
		logic       e_bit;
		logic       pow_done;
	} stat_t;

	function automatic logic [MW-1:0] csub(input logic [MW:0] v, input logic [MW-1:0] m);
		logic [MW:0] d;
		d = v - {1'b0, m};
		return (v >= {1'b0, m}) ? d[MW-1:0] : v[MW-1:0];
	endfunction
endpackage
`default_nettype wire

/* sv/mau_dp.sv */
// Datapath of the modular arithmetic unit: operand reduction, shift-add
// modular multiplier, extended Euclid with restoring division. Uses mau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mau_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mau_pkg::cmd_t cmd,
	input  wire mau_pkg::req_t req,
	input  wire logic          cfg_we,
	input  wire logic [30:0]   cfg_data,
	output mau_pkg::stat_t     stat,
	output mau_pkg::rsp_t      rsp
);
	import mau_pkg::*;

	logic [MW-1:0]     mod_q;
	logic [2:0]        op_q;
	logic [OPW-1:0]    sa_q, sb_q, exp_q;
	logic              na_q, nb_q;
	logic [MW-1:0]     ra_q, rb_q, a_q, b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ECNT_W-1:0] ecnt_q;
	logic [MW-1:0]     x_q, y_q, p_q, acc_q, sq_q, inv_q;
	logic [MW-1:0]     or_q, r_q, rem_q, dv_q;
	logic signed [SW-1:0] os_q, s_q, qs_q;
	logic [MW-1:0]     res_q;
	logic              flag_q;

	logic [MW-1:0] ra_n, rb_n, md, ms, addsub_n, pd_rem, inv_n;
	logic [MW:0]   pd, diff;
	logic          ge;
	logic signed [SW-1:0] mext, iv;

	always_comb begin
		ra_n = csub({ra_q, sa_q[OPW-1]}, mod_q);
		rb_n = csub({rb_q, sb_q[OPW-1]}, mod_q);
		md = csub({p_q, 1'b0}, mod_q);
		ms = y_q[MW-1] ? csub({1'b0, md} + {1'b0, x_q}, mod_q) : md;
		if (op_q == OP_ADD) begin
			diff = {1'b0, a_q} + {1'b0, b_q};
		end else begin
			diff = {1'b0, a_q} + {1'b0, mod_q} - {1'b0, b_q};
		end
		addsub_n = csub(diff, mod_q);
		pd = {rem_q, dv_q[MW-1]};
		ge = pd >= {1'b0, r_q};
		pd_rem = ge ? MW'(pd - {1'b0, r_q}) : pd[MW-1:0];
		mext = SW'(mod_q);
		iv = os_q[SW-1] ? os_q + mext : os_q;
		inv_n = (iv >= mext) ? MW'(iv - mext) : iv[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET;
		end else if (cfg_we) begin
			mod_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q  <= req.opcode;
				na_q  <= req.operand_a[OPW-1];
				nb_q  <= req.operand_b[OPW-1];
				sa_q  <= req.operand_a[OPW-1] ? OPW'(-req.operand_a) : req.operand_a;
				sb_q  <= req.operand_b[OPW-1] ? OPW'(-req.operand_b) : req.operand_b;
				exp_q <= req.exponent;
				ra_q  <= '0;
				rb_q  <= '0;
				cnt_q <= '0;
			end
			CMD_RED: begin
				ra_q  <= ra_n;
				rb_q  <= rb_n;
				sa_q  <= sa_q << 1;
				sb_q  <= sb_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			CMD_FIX: begin
				a_q <= (na_q && ra_q != '0) ? mod_q - ra_q : ra_q;
				b_q <= (nb_q && rb_q != '0) ? mod_q - rb_q : rb_q;
			end
			CMD_ADDSUB: begin
				res_q  <= addsub_n;
				flag_q <= 1'b0;
			end
			CMD_ZERO: begin
				res_q  <= '0;
				flag_q <= 1'b0;
			end
			CMD_FLAG: begin
				res_q  <= '0;
				flag_q <= 1'b1;
			end
			CMD_MSET_AB, CMD_MSET_AI, CMD_MSET_PA, CMD_MSET_PS: begin
				x_q   <= (cmd == CMD_MSET_PA) ? acc_q :
					(cmd == CMD_MSET_PS) ? sq_q : a_q;
				y_q   <= (cmd == CMD_MSET_AB) ? b_q :
					(cmd == CMD_MSET_AI) ? inv_q : sq_q;
				p_q   <= '0;
				cnt_q <= '0;
			end
			CMD_MSTEP: begin
				p_q   <= ms;
				y_q   <= y_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			CMD_MWB_RES: begin
				res_q  <= p_q;
				flag_q <= 1'b0;
			end
			CMD_MWB_ACC: acc_q <= p_q;
			CMD_MWB_SQ: begin
				sq_q   <= p_q;
				exp_q  <= exp_q >> 1;
				ecnt_q <= ecnt_q + 1'b1;
			end
			CMD_POW_INIT: begin
				acc_q  <= MW'(1);
				sq_q   <= a_q;
				ecnt_q <= '0;
			end
			CMD_POW_RES: begin
				res_q  <= acc_q;
				flag_q <= 1'b0;
			end
			CMD_EU_INIT: begin
				or_q <= b_q;
				r_q  <= mod_q;
				os_q <= SW'(1);
				s_q  <= '0;
			end
			CMD_EU_DSET: begin
				dv_q  <= or_q;
				rem_q <= '0;
				qs_q  <= '0;
				cnt_q <= '0;
			end
			CMD_EU_DSTEP: begin
				rem_q <= pd_rem;
				dv_q  <= dv_q << 1;
				qs_q  <= (qs_q <<< 1) + (ge ? s_q : SW'(0));
				cnt_q <= cnt_q + 1'b1;
			end
			CMD_EU_UPD: begin
				or_q <= r_q;
				r_q  <= rem_q;
				os_q <= s_q;
				s_q  <= os_q - qs_q;
			end
			CMD_EU_FIN: inv_q <= inv_n;
			default: ;
		endcase
	end

	always_comb begin
		stat.op        = op_q;
		stat.mod_small = mod_q < MW'(2);
		stat.red_last  = cnt_q == RED_LAST;
		stat.mul_last  = cnt_q == MUL_LAST;
		stat.r_zero    = r_q == '0;
		stat.inv_ok    = or_q == MW'(1);
		stat.e_bit     = exp_q[0];
		stat.pow_done  = ecnt_q == ECNT_W'(EXP_BITS);
		rsp.result     = res_q;
		rsp.no_inverse = flag_q;
	end
endmodule
`default_nettype wire

/* sv/mau_ctrl.sv */
// Controller of the modular arithmetic unit: sequences the datapath
// through reduction, multiply, Euclid and power loops. Uses mau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mau_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire mau_pkg::stat_t stat,
	output mau_pkg::cmd_t       cmd,
	output logic                busy,
	output logic                done
);
	import mau_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001, S_CHK    = 18'h00002, S_RED    = 18'h00004,
		S_FIX    = 18'h00008, S_DISP   = 18'h00010, S_MUL    = 18'h00020,
		S_MWB    = 18'h00040, S_EU_CHK = 18'h00080, S_EU_DIV = 18'h00100,
		S_EU_UPD = 18'h00200, S_EU_INV = 18'h00400, S_P_CHK  = 18'h00800,
		S_P_MUL1 = 18'h01000, S_P_WBA  = 18'h02000, S_P_SQ   = 18'h04000,
		S_P_MUL2 = 18'h08000, S_P_WBS  = 18'h10000, S_DONE   = 18'h20000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd = CMD_LOAD;
					state_n = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.mod_small) begin
					cmd = CMD_ZERO;
					state_n = S_DONE;
				end else begin
					state_n = S_RED;
				end
			end
			S_RED: begin
				cmd = CMD_RED;
				if (stat.red_last) state_n = S_FIX;
			end
			S_FIX: begin
				cmd = CMD_FIX;
				state_n = S_DISP;
			end
			S_DISP: begin
				unique case (stat.op) inside
					OP_ADD, OP_SUB: begin
						cmd = CMD_ADDSUB;
						state_n = S_DONE;
					end
					OP_MUL: begin
						cmd = CMD_MSET_AB;
						state_n = S_MUL;
					end
					OP_DIV: begin
						cmd = CMD_EU_INIT;
						state_n = S_EU_CHK;
					end
					OP_POW: begin
						cmd = CMD_POW_INIT;
						state_n = S_P_CHK;
					end
					default: begin
						cmd = CMD_ZERO;
						state_n = S_DONE;
					end
				endcase
			end
			S_MUL: begin
				cmd = CMD_MSTEP;
				if (stat.mul_last) state_n = S_MWB;
			end
			S_MWB: begin
				cmd = CMD_MWB_RES;
				state_n = S_DONE;
			end
			S_EU_CHK: begin
				if (!stat.r_zero) begin
					cmd = CMD_EU_DSET;
					state_n = S_EU_DIV;
				end else if (stat.inv_ok) begin
					cmd = CMD_EU_FIN;
					state_n = S_EU_INV;
				end else begin
					cmd = CMD_FLAG;
					state_n = S_DONE;
				end
			end
			S_EU_DIV: begin
				cmd = CMD_EU_DSTEP;
				if (stat.mul_last) state_n = S_EU_UPD;
			end
			S_EU_UPD: begin
				cmd = CMD_EU_UPD;
				state_n = S_EU_CHK;
			end
			S_EU_INV: begin
				cmd = CMD_MSET_AI;
				state_n = S_MUL;
			end
			S_P_CHK: begin
				if (stat.pow_done) begin
					cmd = CMD_POW_RES;
					state_n = S_DONE;
				end else if (stat.e_bit) begin
					cmd = CMD_MSET_PA;
					state_n = S_P_MUL1;
				end else begin
					cmd = CMD_MSET_PS;
					state_n = S_P_MUL2;
				end
			end
			S_P_MUL1: begin
				cmd = CMD_MSTEP;
				if (stat.mul_last) state_n = S_P_WBA;
			end
			S_P_WBA: begin
				cmd = CMD_MWB_ACC;
				state_n = S_P_SQ;
			end
			S_P_SQ: begin
				cmd = CMD_MSET_PS;
				state_n = S_P_MUL2;
			end
			S_P_MUL2: begin
				cmd = CMD_MSTEP;
				if (stat.mul_last) state_n = S_P_WBS;
			end
			S_P_WBS: begin
				cmd = CMD_MWB_SQ;
				state_n = S_P_CHK;
			end
			S_DONE: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
endmodule
`default_nettype wire

/* sv/modular_arithmetic_unit.sv */
// Modular arithmetic unit: add, subtract, multiply, divide and power modulo a
// programmable modulus. Takes a request when start is high and busy is low;
// the answer appears on rsp for exactly one cycle with done high and cannot be
// held off, so the receiver must take it then. busy stays high from the
// request until the cycle after done. Operand reduction works through all 64
// bits of each operand. Each modular product runs on the shared shift-add
// multiplier. Power scans all 64 exponent bits, squaring for each bit and
// multiplying into the accumulator for each set bit. Divide runs extended
// Euclid, each quotient found by restoring division, then one multiply of
// the dividend by the inverse. The modulus is written through cfg_valid/
// cfg_ready while idle. Uses mau_pkg, mau_ctrl and mau_dp.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire mau_pkg::req_t req,
	output logic               done,
	output mau_pkg::rsp_t      rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [30:0]   cfg_data
);
	import mau_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = !busy;

	mau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mau_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire

/* sv/mau_checker.sv */
// Port-level checker for the modular arithmetic unit, bound to the top level.
// Uses modular_arithmetic_unit_defines.svh and mau_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_arithmetic_unit_defines.svh"
module mau_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire mau_pkg::rsp_t rsp,
	input wire logic          cfg_valid,
	input wire logic          cfg_ready
);
	`MAU_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`MAU_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)
	`MAU_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done && !busy)
	`MAU_ASSERT_IMP(a_flag_zero, clk, arst_n, done && rsp.no_inverse, rsp.result == '0)
	`MAU_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_valid && cfg_ready, !busy)
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.rsp       (rsp),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
